FILE: rtl/cwm_pkg.sv
// ----------------------------------------------------------------------------
// cwm_pkg: shared definitions for the clipped window median filter
// Default sizes, pixel widths, register codes, item codes and queue status.
// ----------------------------------------------------------------------------
package cwm_pkg;

    localparam int WINDOW_DEF    = 3;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int CFG_W  = 16;
    localparam int IMG_WW = 11;
    localparam int IMG_HW = 16;

    localparam logic [IMG_WW-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IMG_HW-1:0] HEIGHT_RESET = 16'd480;

    // window queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
    } t_qstat;

    // one queue entry: window pixels, per-slot valid mask, last flag
    function automatic int entry_w(input int window);
        int span;
        span = 2 * (window / 2) + 1;
        return span * span * (PIX_W + 1) + 1;
    endfunction

endpackage

FILE: rtl/cwm_if.sv
// ----------------------------------------------------------------------------
// cwm_if: stream channels of the median filter
// Input channel carries source pixels and flush ticks, output channel results.
// ----------------------------------------------------------------------------
interface cwm_in_if;
    import cwm_pkg::*;
    logic            valid;
    logic            ready;
    logic            op;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, op, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface cwm_out_if;
    import cwm_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_pixel;

    modport source (output valid, red_out, green_out, blue_out, last_pixel, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_pixel, output ready);
endinterface

FILE: rtl/cwm_ram.sv
// ----------------------------------------------------------------------------
// cwm_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cwm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/cwm_front.sv
// ----------------------------------------------------------------------------
// cwm_front: pixel intake, raster counters and banked line store
// Writes source pixels, decides which beats yield a result and fetches the
// clipped window of the next output into the window queue.
// ----------------------------------------------------------------------------
module cwm_front #(
    parameter int WINDOW    = cwm_pkg::WINDOW_DEF,
    parameter int MAX_WIDTH = cwm_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [0:0]                           i_cfg_idx,
    input  logic [cwm_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic [cwm_pkg::PIX_W-1:0]            i_pix,
    input  cwm_pkg::t_qstat                      i_qstat,
    output logic                                 o_push,
    output logic [cwm_pkg::entry_w(WINDOW)-1:0]  o_entry
);
    import cwm_pkg::*;

    localparam int HALF   = WINDOW / 2;
    localparam int SPAN   = 2 * HALF + 1;
    localparam int N      = SPAN * SPAN;
    localparam int RB     = 3 * HALF + 1;
    localparam int ADEPTH = (MAX_WIDTH + SPAN - 1) / SPAN;
    localparam int AW     = $clog2(ADEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CRW    = $clog2(SPAN);
    localparam int RRW    = $clog2(RB);
    localparam int LW     = $clog2(HALF * MAX_WIDTH + HALF + 1);
    localparam int EW     = entry_w(WINDOW);

    function automatic int wrap2(input int x, input int m);
        int y;
        y = x;
        if (y >= m) y = y - m;
        if (y >= m) y = y - m;
        return y;
    endfunction

    logic [IMG_WW-1:0] r_cfg_w;
    logic [IMG_HW-1:0] r_cfg_h;
    logic [WW-1:0]     r_frame_w;
    logic [IMG_HW-1:0] r_frame_h;
    logic [IMG_HW-1:0] r_in_row;
    logic [CW-1:0]     r_in_col;
    logic [AW-1:0]     r_in_cq;
    logic [CRW-1:0]    r_in_cr;
    logic [RRW-1:0]    r_in_rr;
    logic [IMG_HW-1:0] r_out_row;
    logic [CW-1:0]     r_out_col;
    logic [AW-1:0]     r_out_cq;
    logic [CRW-1:0]    r_out_cr;
    logic [RRW-1:0]    r_out_rr;
    logic              r_done;
    logic [LW-1:0]     r_lag;
    logic              r_pend;
    logic              r_last;
    logic              r_ovr;
    logic [PIX_W-1:0]  r_ovr_pix;
    logic [RRW-1:0]    r_a [SPAN];
    logic [CRW-1:0]    r_b [SPAN];
    logic [SPAN-1:0]   r_rowv;
    logic [SPAN-1:0]   r_colv;

    logic              acc, is_pix, first, pix_ok, emit_pix, emit_fl, emit, last;
    logic              in_col_wrap, out_col_wrap, ovr;
    logic [WW-1:0]     w_clamp, w_eff;
    logic [IMG_HW-1:0] h_clamp, h_eff;
    logic [AW-1:0]     rd_addr [SPAN];
    logic [RRW-1:0]    a_sel [SPAN];
    logic [CRW-1:0]    b_sel [SPAN];
    logic [SPAN-1:0]   rowv, colv;
    logic [PIX_W-1:0]  ram_q [RB][SPAN];
    logic [PIX_W-1:0]  rowsel [SPAN][SPAN];

    // hold back while the queue could not take the fetched window
    assign o_ready = (int'(i_qstat.count) + int'(r_pend)) < Q_DEPTH;
    assign acc     = i_valid && o_ready;
    assign is_pix  = (t_op'(i_op) == OP_PIXEL);
    assign first   = (r_in_row == '0) && (r_in_col == '0);

    always_comb begin
        if (r_cfg_w == '0) begin
            w_clamp = WW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(r_cfg_w);
        end
        h_clamp = (r_cfg_h == '0) ? IMG_HW'(1) : r_cfg_h;
    end

    assign w_eff    = first ? w_clamp : r_frame_w;
    assign h_eff    = first ? h_clamp : r_frame_h;
    assign pix_ok   = acc && is_pix && !r_done;
    assign emit_pix = pix_ok && !first && (r_lag == '0);
    assign emit_fl  = acc && !is_pix && r_done;
    assign emit     = emit_pix || emit_fl;
    assign last     = ((IMG_HW + 1)'(r_out_row) + 1'b1 == (IMG_HW + 1)'(r_frame_h)) &&
                      (WW'(r_out_col) + WW'(1) == r_frame_w);
    assign in_col_wrap  = (WW'(r_in_col) + WW'(1) == w_eff);
    assign out_col_wrap = (WW'(r_out_col) + WW'(1) == r_frame_w);
    // bottom right neighbor is the pixel written in this very beat
    assign ovr = emit_pix && (int'(r_out_col) + HALF < int'(r_frame_w));

    // read address per column bank and bank selection per window slot
    always_comb begin
        int db;
        int t;
        for (int b = 0; b < SPAN; b++) begin
            db = wrap2(b + HALF + SPAN - int'(r_out_cr), SPAN);
            t  = int'(r_out_cr) + db;
            if (t < HALF) begin
                rd_addr[b] = r_out_cq - AW'(1);
            end else if (t < HALF + SPAN) begin
                rd_addr[b] = r_out_cq;
            end else begin
                rd_addr[b] = r_out_cq + AW'(1);
            end
        end
        for (int k = 0; k < SPAN; k++) begin
            a_sel[k] = RRW'(wrap2(int'(r_out_rr) + RB - HALF + k, RB));
            b_sel[k] = CRW'(wrap2(int'(r_out_cr) + SPAN - HALF + k, SPAN));
            rowv[k]  = (int'(r_out_row) + k >= HALF) &&
                       (int'(r_out_row) + k - HALF < int'(r_frame_h));
            colv[k]  = (int'(r_out_col) + k >= HALF) &&
                       (int'(r_out_col) + k - HALF < int'(r_frame_w));
        end
    end

    for (genvar a = 0; a < RB; a++) begin : g_row_bank
        for (genvar b = 0; b < SPAN; b++) begin : g_col_bank
            cwm_ram #(
                .WIDTH (PIX_W),
                .DEPTH (ADEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (pix_ok && (r_in_rr == RRW'(a)) && (r_in_cr == CRW'(b))),
                .i_waddr (r_in_cq),
                .i_wdata (i_pix),
                .i_raddr (rd_addr[b]),
                .o_rdata (ram_q[a][b])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= WIDTH_RESET;
            r_cfg_h   <= HEIGHT_RESET;
            r_frame_w <= WW'(1);
            r_frame_h <= IMG_HW'(1);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_cq   <= '0;
            r_in_cr   <= '0;
            r_in_rr   <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_out_cq  <= '0;
            r_out_cr  <= '0;
            r_out_rr  <= '0;
            r_done    <= 1'b0;
            r_lag     <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_pend <= emit;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[IMG_WW-1:0];
                    CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[IMG_HW-1:0];
                    default:          r_cfg_h <= r_cfg_h;
                endcase
            end
            if (pix_ok) begin
                if (first) begin
                    r_frame_w <= w_clamp;
                    r_frame_h <= h_clamp;
                    r_lag     <= LW'(HALF * int'(w_clamp) + HALF - 1);
                end else if (r_lag != '0) begin
                    r_lag <= r_lag - LW'(1);
                end
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    r_in_cq  <= '0;
                    r_in_cr  <= '0;
                    r_in_row <= r_in_row + IMG_HW'(1);
                    r_in_rr  <= (r_in_rr == RRW'(RB - 1)) ? '0 : r_in_rr + RRW'(1);
                    if ((IMG_HW + 1)'(r_in_row) + 1'b1 == (IMG_HW + 1)'(h_eff)) begin
                        r_done <= 1'b1;
                    end
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                    if (r_in_cr == CRW'(SPAN - 1)) begin
                        r_in_cr <= '0;
                        r_in_cq <= r_in_cq + AW'(1);
                    end else begin
                        r_in_cr <= r_in_cr + CRW'(1);
                    end
                end
            end
            if (emit) begin
                if (out_col_wrap) begin
                    r_out_col <= '0;
                    r_out_cq  <= '0;
                    r_out_cr  <= '0;
                    r_out_row <= r_out_row + IMG_HW'(1);
                    r_out_rr  <= (r_out_rr == RRW'(RB - 1)) ? '0 : r_out_rr + RRW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                    if (r_out_cr == CRW'(SPAN - 1)) begin
                        r_out_cr <= '0;
                        r_out_cq <= r_out_cq + AW'(1);
                    end else begin
                        r_out_cr <= r_out_cr + CRW'(1);
                    end
                end
            end
            // last flush: restart for a new image
            if (emit_fl && last) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_in_cq   <= '0;
                r_in_cr   <= '0;
                r_in_rr   <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
                r_out_cq  <= '0;
                r_out_cr  <= '0;
                r_out_rr  <= '0;
                r_done    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last    <= last;
        r_ovr     <= ovr;
        r_ovr_pix <= i_pix;
        r_rowv    <= rowv;
        r_colv    <= colv;
        for (int k = 0; k < SPAN; k++) begin
            r_a[k] <= a_sel[k];
            r_b[k] <= b_sel[k];
        end
    end

    // assemble the window from the bank read data
    always_comb begin
        for (int k = 0; k < SPAN; k++) begin
            for (int b = 0; b < SPAN; b++) begin
                rowsel[k][b] = ram_q[r_a[k]][b];
            end
        end
        o_entry = '0;
        for (int k = 0; k < SPAN; k++) begin
            for (int d = 0; d < SPAN; d++) begin
                if (r_ovr && (k == SPAN - 1) && (d == SPAN - 1)) begin
                    o_entry[(k * SPAN + d) * PIX_W +: PIX_W] = r_ovr_pix;
                end else begin
                    o_entry[(k * SPAN + d) * PIX_W +: PIX_W] = rowsel[k][r_b[d]];
                end
                o_entry[N * PIX_W + k * SPAN + d] = r_rowv[k] & r_colv[d];
            end
        end
        o_entry[EW-1] = r_last;
    end

    assign o_push = r_pend;

`ifndef SYNTHESIS
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fl && last) |=> (r_in_row == '0 && r_in_col == '0 && !r_done))
        else $error("front did not restart after the last output");
    a_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_ok |=> (WW'(r_out_col) < r_frame_w && WW'(r_in_col) < r_frame_w))
        else $error("raster column beyond the latched width");
`endif
endmodule

FILE: rtl/cwm_queue.sv
// ----------------------------------------------------------------------------
// cwm_queue: short window queue
// Decouples the line store fetch from the median pipeline.
// ----------------------------------------------------------------------------
module cwm_queue #(
    parameter int DW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [DW-1:0]   i_data,
    input  logic            i_pop,
    output logic [DW-1:0]   o_data,
    output cwm_pkg::t_qstat o_qstat
);
    import cwm_pkg::*;

    logic [DW-1:0]      r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_head;
    logic [Q_PTR_W-1:0] r_tail;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_data        = r_mem[r_head];
    assign o_qstat.count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (int'(r_count) < Q_DEPTH || i_pop))
        else $error("window queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("window queue underflow");
`endif
endmodule

FILE: rtl/cwm_back.sv
// ----------------------------------------------------------------------------
// cwm_back: median pipeline
// Rank each valid window value per channel and select the one at rank n/2.
// ----------------------------------------------------------------------------
module cwm_back #(
    parameter int WINDOW = cwm_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cwm_pkg::t_qstat                     i_qstat,
    input  logic [cwm_pkg::entry_w(WINDOW)-1:0] i_entry,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [cwm_pkg::CH_W-1:0]            o_red,
    output logic [cwm_pkg::CH_W-1:0]            o_green,
    output logic [cwm_pkg::CH_W-1:0]            o_blue,
    output logic                                o_last
);
    import cwm_pkg::*;

    localparam int HALF = WINDOW / 2;
    localparam int SPAN = 2 * HALF + 1;
    localparam int N    = SPAN * SPAN;
    localparam int NW   = $clog2(N + 1);
    localparam int EW   = entry_w(WINDOW);

    logic             en;
    logic [PIX_W-1:0] e_pix [N];
    logic [N-1:0]     e_valid;
    logic [N-1:0]     lt [3][N];
    logic [N-1:0]     sel [3];
    logic [CH_W-1:0]  med [3];

    logic             r_s1_v;
    logic [PIX_W-1:0] r_s1_pix [N];
    logic [N-1:0]     r_s1_valid;
    logic [NW-1:0]    r_s1_half;
    logic             r_s1_last;
    logic [N-1:0]     r_s1_lt [3][N];
    logic             r_s2_v;
    logic [PIX_W-1:0] r_s2_pix [N];
    logic [N-1:0]     r_s2_sel [3];
    logic             r_s2_last;
    logic             r_out_v;
    logic [CH_W-1:0]  r_out_ch [3];
    logic             r_out_last;

    // advance all stages together unless the result is held
    assign en    = !r_out_v || i_ready;
    assign o_pop = en && (i_qstat.count != '0);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            e_pix[i] = i_entry[i * PIX_W +: PIX_W];
        end
        e_valid = i_entry[N * PIX_W +: N];
    end

    // pairwise order with ties broken by slot index gives unique ranks
    always_comb begin
        logic [CH_W-1:0] vi;
        logic [CH_W-1:0] vj;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < N; i++) begin
                for (int j = 0; j < N; j++) begin
                    vi = e_pix[i][PIX_W - 1 - CH_W * ch -: CH_W];
                    vj = e_pix[j][PIX_W - 1 - CH_W * ch -: CH_W];
                    lt[ch][i][j] = e_valid[j] && ((vj < vi) || ((vj == vi) && (j < i)));
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < N; i++) begin
                sel[ch][i] = r_s1_valid[i] &&
                             (NW'($countones(r_s1_lt[ch][i])) == r_s1_half);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            med[ch] = '0;
            for (int i = 0; i < N; i++) begin
                if (r_s2_sel[ch][i]) begin
                    med[ch] = med[ch] | r_s2_pix[i][PIX_W - 1 - CH_W * ch -: CH_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= o_pop;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_valid <= e_valid;
            r_s1_half  <= NW'($countones(e_valid) >> 1);
            r_s1_last  <= i_entry[EW-1];
            r_s2_last  <= r_s1_last;
            r_out_last <= r_s2_last;
            for (int i = 0; i < N; i++) begin
                r_s1_pix[i] <= e_pix[i];
                r_s2_pix[i] <= r_s1_pix[i];
            end
            for (int ch = 0; ch < 3; ch++) begin
                r_s2_sel[ch] <= sel[ch];
                r_out_ch[ch] <= med[ch];
                for (int i = 0; i < N; i++) begin
                    r_s1_lt[ch][i] <= lt[ch][i];
                end
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_red   = r_out_ch[0];
    assign o_green = r_out_ch[1];
    assign o_blue  = r_out_ch[2];
    assign o_last  = r_out_last;
endmodule

FILE: rtl/clipped_window_median_filter.sv
// ----------------------------------------------------------------------------
// clipped_window_median_filter: RGB median over a border-clipped window
// Top level: intake front, window queue and median back end.
// ----------------------------------------------------------------------------
// Takes one beat per clock on i_pix, source pixels in raster order or flush
// ticks, and returns per channel the median of the SPAN x SPAN neighborhood
// (SPAN = 2*(WINDOW/2)+1) of each pixel, cut down at the image borders; with
// an even count the upper median is given. Output pixel q leaves with source
// pixel q + (WINDOW/2)*width + WINDOW/2; after the last source pixel send one
// flush beat per pending output, the final one carries last_pixel and starts
// a new image. Width and height are sampled at the first pixel of an image.
// Sustained rate is one beat per clock while ready is high: the line store
// is split into (3*(WINDOW/2)+1) x SPAN RAM banks by row and column residue,
// so a whole window is fetched with one read per bank while the incoming
// pixel is written. The bank read happens on the accepting edge; the
// registered window is then written into the window queue and passes the
// three stages of rank, select and output.
// The window queue lets intake run on while the output is stalled; i_pix
// drops ready when the queue has no room left beyond the window in flight.
// ----------------------------------------------------------------------------
module clipped_window_median_filter #(
    parameter int WINDOW    = cwm_pkg::WINDOW_DEF,
    parameter int MAX_WIDTH = cwm_pkg::MAX_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [cwm_pkg::CFG_W-1:0] i_cfg_data,
    cwm_in_if.sink                    i_pix,
    cwm_out_if.source                 o_pix
);
    import cwm_pkg::*;

    localparam int EW = entry_w(WINDOW);

    t_qstat         qstat;
    logic           push;
    logic           pop;
    logic           front_ready;
    logic [EW-1:0]  entry_in;
    logic [EW-1:0]  entry_out;

    // intake: count the raster, write the store, fetch the window
    cwm_front #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_pix.valid),
        .o_ready    (front_ready),
        .i_op       (i_pix.op),
        .i_pix      ({i_pix.red_in, i_pix.green_in, i_pix.blue_in}),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_entry    (entry_in)
    );

    assign i_pix.ready = front_ready;

    // hold fetched windows until the median pipeline advances
    cwm_queue #(
        .DW (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry_in),
        .i_pop   (pop),
        .o_data  (entry_out),
        .o_qstat (qstat)
    );

    // rank, select and present the result beat
    cwm_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_entry (entry_out),
        .o_pop   (pop),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_red   (o_pix.red_out),
        .o_green (o_pix.green_out),
        .o_blue  (o_pix.blue_out),
        .o_last  (o_pix.last_pixel)
    );
endmodule
